// ===== rtl/gspg_pkg.sv =====
package gspg_pkg;

   // Geometry of one strip
   localparam int STRIP_ROWS = 16;
   localparam int ROW_PIXELS = 15;

   // Field widths
   localparam int COLOR_W = 6;
   localparam int ROW_W   = 4;
   localparam int PIXEL_W = 16;
   localparam int COL_W   = 4;
   localparam int FMT_W   = 2;
   localparam int CHANS   = 3;

   // Stream data widths (fields packed from bit 0, padded to whole bytes)
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   // 5.16 color levels; every level in use stays below 2^21
   localparam int LEVEL_W = 21;
   localparam logic [LEVEL_W-1:0] LOW_LEVEL  = LEVEL_W'(32'h0000_8000);
   localparam logic [LEVEL_W-1:0] HIGH_LEVEL = LEVEL_W'(32'h001F_8000);
   localparam int LEVEL_SPAN = 32'h001F_8000 - 32'h0000_8000;

   // Per-row move of an endpoint, truncated toward zero
   localparam logic [LEVEL_W-1:0] ROW_DELTA = LEVEL_W'(LEVEL_SPAN / STRIP_ROWS);
   localparam int ROW_MAX = STRIP_ROWS - 1;

   // Divide by ROW_PIXELS through a rounded-up reciprocal
   localparam int DIV_SHIFT = 28;
   localparam int RECIP_W   = 28;
   localparam logic [RECIP_W-1:0] DIV_RECIP =
      RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(ROW_PIXELS) - 64'd1) / 64'(ROW_PIXELS));
   localparam int PROD_W = LEVEL_W + RECIP_W;

   localparam logic [COL_W-1:0] LAST_COL = COL_W'(ROW_PIXELS - 1);

   // Pixel format codes
   localparam logic [FMT_W-1:0] FMT_PACK16 = 2'd0;
   localparam logic [FMT_W-1:0] FMT_RGB555 = 2'd1;
   localparam logic [FMT_W-1:0] FMT_INDEX  = 2'd2;

   // One row worth of interpolation setup
   typedef struct packed {
      logic [CHANS-1:0][LEVEL_W-1:0] top;
      logic [CHANS-1:0]              neg;
      logic [CHANS-1:0][LEVEL_W-1:0] step;
   } row_item_type;

   // Endpoint level moved row steps toward the next strip's level
   function automatic logic [LEVEL_W-1:0] row_level(input logic cur_bit,
                                                    input logic nxt_bit,
                                                    input logic [ROW_W-1:0] row);
      logic [LEVEL_W+ROW_W-1:0] moved;
      logic [LEVEL_W-1:0]       base;
      moved = (LEVEL_W+ROW_W)'(row) * (LEVEL_W+ROW_W)'(ROW_DELTA);
      base  = cur_bit ? HIGH_LEVEL : LOW_LEVEL;
      if (cur_bit == nxt_bit) begin
         return base;
      end else if (cur_bit) begin
         return base - moved[LEVEL_W-1:0];
      end else begin
         return base + moved[LEVEL_W-1:0];
      end
   endfunction

endpackage

// ===== rtl/gspg_front.sv =====
module gspg_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [gspg_pkg::COLOR_W-1:0] this_colors,
   input  logic [gspg_pkg::COLOR_W-1:0] next_colors,
   input  logic [gspg_pkg::ROW_W-1:0]   row_index,
   output logic                        out_valid,
   input  logic                        out_ready,
   output gspg_pkg::row_item_type      out_item
);

   localparam int LW = gspg_pkg::LEVEL_W;
   localparam int NC = gspg_pkg::CHANS;

   // Stage 1: row endpoints
   logic                    s1_valid_ff;
   logic [NC-1:0][LW-1:0]   s1_top_ff, s1_top_in;
   logic [NC-1:0][LW-1:0]   s1_bot_ff, s1_bot_in;
   // Stage 2: span magnitude and direction
   logic                    s2_valid_ff;
   logic [NC-1:0][LW-1:0]   s2_top_ff;
   logic [NC-1:0]           s2_neg_ff, s2_neg_in;
   logic [NC-1:0][LW-1:0]   s2_mag_ff, s2_mag_in;
   // Stage 3: per-pixel step
   logic                    s3_valid_ff;
   logic [NC-1:0][LW-1:0]   s3_top_ff;
   logic [NC-1:0]           s3_neg_ff;
   logic [NC-1:0][LW-1:0]   s3_step_ff, s3_step_in;

   logic                    s1_ready, s2_ready, s3_ready;
   logic [gspg_pkg::ROW_W-1:0] row_clamped;
   logic [NC-1:0][gspg_pkg::PROD_W-1:0] prod;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_comb begin
      row_clamped = row_index;
      if (int'(row_index) > gspg_pkg::ROW_MAX) begin
         row_clamped = gspg_pkg::ROW_W'(gspg_pkg::ROW_MAX);
      end
      for (int c = 0; c < NC; c++) begin
         s1_top_in[c] = gspg_pkg::row_level(this_colors[c], next_colors[c], row_clamped);
         s1_bot_in[c] = gspg_pkg::row_level(this_colors[c+NC], next_colors[c+NC],
                                            row_clamped);
         s2_neg_in[c] = s1_bot_ff[c] < s1_top_ff[c];
         s2_mag_in[c] = s2_neg_in[c] ? (s1_top_ff[c] - s1_bot_ff[c])
                                     : (s1_bot_ff[c] - s1_top_ff[c]);
         prod[c] = gspg_pkg::PROD_W'(s2_mag_ff[c]) *
                   gspg_pkg::PROD_W'(gspg_pkg::DIV_RECIP);
         s3_step_in[c] = prod[c][gspg_pkg::DIV_SHIFT +: LW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_top_ff <= s1_top_in;
         s1_bot_ff <= s1_bot_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_top_ff <= s1_top_ff;
         s2_neg_ff <= s2_neg_in;
         s2_mag_ff <= s2_mag_in;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_top_ff  <= s2_top_ff;
         s3_neg_ff  <= s2_neg_ff;
         s3_step_ff <= s3_step_in;
      end
   end

   assign out_valid     = s3_valid_ff;
   assign out_item.top  = s3_top_ff;
   assign out_item.neg  = s3_neg_ff;
   assign out_item.step = s3_step_ff;

endmodule

// ===== rtl/gradient_strip_pixel_generator_top.sv =====
// Channel | Direction | Handshake          | Payload
// req     | in        | req_tvalid/tready  | tdata: this_colors, next_colors, row_index
// rsp     | out       | rsp_tvalid/tready  | tdata: pixel, column; tlast: last
// csr     | in        | csr_wen            | csr_wdata: pixel_format
//
// A row transaction passes three setup stages (endpoints, span, reciprocal multiply);
// the column stage then emits ROW_PIXELS pixels, one per cycle while rsp accepts, through
// the output register, at the pace set by the single result channel.
// The next row waits set up and loads in the cycle the last pixel leaves the column stage.
// Reset (synchronous, active high) empties every stage and sets pixel_format to 0.
// A stalled rsp side holds the output register and column stage; setup fills, req_tready drops.
module gradient_strip_pixel_generator_top (
   input  logic                             clock,
   input  logic                             reset,
   // this_colors [5:0], next_colors [11:6], row_index [15:12]
   input  logic [gspg_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // pixel [15:0], column [19:16], zero fill [23:20]
   output logic [gspg_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_wen,
   input  logic [gspg_pkg::FMT_W-1:0]       csr_wdata
);

   localparam int LW = gspg_pkg::LEVEL_W;
   localparam int NC = gspg_pkg::CHANS;
   localparam int CW = gspg_pkg::COL_W;

   logic [gspg_pkg::FMT_W-1:0] fmt_ff;

   logic                   row_valid;
   logic                   row_ready;
   gspg_pkg::row_item_type row_item;

   // Column stage: running color per channel and the column count
   logic                  col_valid_ff;
   logic [NC-1:0][LW-1:0] acc_ff, acc_in;
   logic [NC-1:0]         neg_ff;
   logic [NC-1:0][LW-1:0] step_ff;
   logic [CW-1:0]         col_ff;
   logic                  col_load;
   logic                  col_fire;
   logic                  col_done;

   // Output register
   logic                           out_ready;
   logic [gspg_pkg::PIXEL_W-1:0]   pixel_in, pixel_ff;
   logic [CW-1:0]                  column_ff;
   logic                           last_ff;
   logic [4:0]                     red, green, blue;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= gspg_pkg::FMT_PACK16;
      end else if (csr_wen) begin
         fmt_ff <= csr_wdata;
      end
   end

   gspg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .this_colors (req_tdata[5:0]),
      .next_colors (req_tdata[11:6]),
      .row_index   (req_tdata[15:12]),
      .out_valid   (row_valid),
      .out_ready   (row_ready),
      .out_item    (row_item)
   );

   assign out_ready = !rsp_tvalid || rsp_tready;
   assign col_fire  = col_valid_ff && out_ready;
   assign col_done  = col_fire && (col_ff == gspg_pkg::LAST_COL);
   assign row_ready = !col_valid_ff || col_done;
   assign col_load  = row_ready && row_valid;

   // Advance each channel by its step; the sign never carries it out of range
   always_comb begin
      for (int c = 0; c < NC; c++) begin
         acc_in[c] = neg_ff[c] ? (acc_ff[c] - step_ff[c]) : (acc_ff[c] + step_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_valid_ff <= 1'b0;
         col_ff       <= '0;
      end else if (col_load) begin
         col_valid_ff <= 1'b1;
         col_ff       <= '0;
      end else if (col_fire) begin
         col_valid_ff <= !col_done;
         col_ff       <= col_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (col_load) begin
         acc_ff  <= row_item.top;
         neg_ff  <= row_item.neg;
         step_ff <= row_item.step;
      end else if (col_fire) begin
         acc_ff  <= acc_in;
      end
   end

   // Integer part of each channel, then pack by format
   assign red   = acc_ff[0][LW-1:16];
   assign green = acc_ff[1][LW-1:16];
   assign blue  = acc_ff[2][LW-1:16];

   always_comb begin
      case (fmt_ff)
         gspg_pkg::FMT_PACK16: begin
            pixel_in = {red, green, 1'b0, blue};
         end
         gspg_pkg::FMT_RGB555,
         gspg_pkg::FMT_INDEX: begin
            pixel_in = {1'b0, red, green, blue};
         end
         default: begin
            pixel_in = {1'b0, red, green, blue};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (out_ready) begin
         rsp_tvalid <= col_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (col_fire) begin
         pixel_ff  <= pixel_in;
         column_ff <= col_ff;
         last_ff   <= (col_ff == gspg_pkg::LAST_COL);
      end
   end

   assign rsp_tdata = {4'b0, column_ff, pixel_ff};
   assign rsp_tlast = last_ff;

   // The final pixel of a row always sits in the last column
   a_last_col: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (column_ff == gspg_pkg::LAST_COL)))
      else $error("tlast does not match the last column");

   // A freshly loaded row starts at column zero
   a_load_col0: assert property (@(posedge clock) disable iff (reset)
      col_load |=> (col_valid_ff && col_ff == '0))
      else $error("row load did not restart the column count");

   // A blocked column stage holds its running color and column
   a_col_hold: assert property (@(posedge clock) disable iff (reset)
      (col_valid_ff && !out_ready) |=> ($stable(acc_ff) && $stable(col_ff)))
      else $error("column stage moved while output was stalled");

   // A set-up row waiting on the column stage is kept
   a_row_hold: assert property (@(posedge clock) disable iff (reset)
      (row_valid && !row_ready) |=> row_valid)
      else $error("set-up row dropped while column stage busy");

endmodule
